>>> rtl/wwl_pkg.sv
// Shared types and constants for the word wrap text layout unit.
`default_nettype none
package wwl_pkg;

  localparam int WORD_BUFFER_DEPTH_DEF = 60;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] CPL_RESET = 6'd52;
  localparam logic [6:0] LPP_RESET = 7'd15;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ZERO = 8'd0;

  localparam logic REG_CPL = 1'b0;
  localparam logic REG_LPP = 1'b1;

  typedef logic [1:0] cls_t;
  localparam cls_t CLS_OTHER = 2'd0;
  localparam cls_t CLS_NL = 2'd1;
  localparam cls_t CLS_SP = 2'd2;
  localparam cls_t CLS_ZERO = 2'd3;

  typedef struct packed {
    cls_t cls;
    logic [7:0] chr;
    logic eot;
  } item_t;

  typedef struct packed {
    logic [5:0] cpl;
    logic [6:0] lpp;
  } cfg_t;

  typedef struct packed {
    logic draw;
    logic wipe_before;
    logic [7:0] glyph;
    logic [5:0] column;
    logic [5:0] row;
    logic last;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/word_wrap_text_layout_unit.sv
// Top level of the word wrap text layout unit: register port, input queue and sequencer.
//
// Text enters one byte per beat on the in_ channel (valid/stall); each accepted byte yields
// zero or more result beats on the out_ channel, the final one of them marked by out_last.
// A result is a drawn glyph at column/row, or a wipe-only beat with out_draw low.
// A two-entry queue parts the input side from the sequencer, so bytes are taken while
// the sequencer works or while a result waits in the output register.
// The sequencer produces at most one result per cycle. A byte that is only buffered as
// part of a word is taken in the head state; a byte that is drawn directly passes the
// head, act and fin states; a word flush makes the space decision and then places each
// buffered byte in turn; a wipe-only result adds the flush state. The word buffer is a
// RAM with registered read, read one entry per cycle during a flush unless the
// sequencer is halted by a stall on the out_ channel.
// A stall on the out_ channel holds the output register and, once the one-result
// holding stage is full too, halts the sequencer; the queue then fills and in_stall rises.
// Reset (rst_n low, synchronous) empties the queue, homes the cursor, clears the pending
// space and word length and loads 52 columns and 15 rows; the word buffer is not cleared.
// Registers: byte address 0 holds the line length in cells, byte address 4 the page height.
`default_nettype none
module word_wrap_text_layout_unit #(
  parameter int WORD_BUFFER_DEPTH = wwl_pkg::WORD_BUFFER_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_character,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_draw,
  output logic             out_wipe_before,
  output logic [7:0]       out_glyph,
  output logic [5:0]       out_column,
  output logic [5:0]       out_row,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import wwl_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cfg_wr;
  logic q_vld;
  item_t q_item;
  logic q_pop;
  result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_CPL: cfg_nxt.cpl = pwdata[5:0];
        REG_LPP: cfg_nxt.lpp = pwdata[6:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CPL: prdata = {26'd0, cfg_r.cpl};
      REG_LPP: prdata = {25'd0, cfg_r.lpp};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpl <= CPL_RESET;
      cfg_r.lpp <= LPP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wwl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_character   (in_character),
    .in_end_of_text (in_end_of_text),
    .q_vld          (q_vld),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  wwl_back #(
    .DEPTH (WORD_BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_draw = res.draw;
  assign out_wipe_before = res.wipe_before;
  assign out_glyph = res.glyph;
  assign out_column = res.column;
  assign out_row = res.row;
  assign out_last = res.last;

endmodule
`default_nettype wire

>>> rtl/wwl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module wwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 60
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/wwl_front.sv
// Input side: accepts text beats, classifies each byte and queues it for the sequencer.
`default_nettype none
module wwl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_character,
  input  wire logic          in_end_of_text,
  output logic               q_vld,
  output wwl_pkg::item_t     q_item,
  input  wire logic          q_pop
);
  import wwl_pkg::*;

  localparam int QD = QUEUE_DEPTH;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  item_t q_mem [QD];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic push;
  item_t new_item;

  always_comb begin
    new_item.chr = in_character;
    new_item.eot = in_end_of_text;
    case (in_character)
      CH_NEWLINE: new_item.cls = CLS_NL;
      CH_SPACE: new_item.cls = CLS_SP;
      CH_ZERO: new_item.cls = CLS_ZERO;
      default: new_item.cls = CLS_OTHER;
    endcase
  end

  assign in_stall = (cnt_r == CW'(QD));
  assign push = in_valid & ~in_stall;
  assign q_vld = (cnt_r != '0);
  assign q_item = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (q_pop && q_vld) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !(q_pop && q_vld)) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && q_pop && q_vld) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/wwl_back.sv
// Layout sequencer: cursor, word buffer, wrap decisions and the result output register.
`default_nettype none
module wwl_back #(
  parameter int DEPTH = wwl_pkg::WORD_BUFFER_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire wwl_pkg::cfg_t  cfg,
  input  wire logic           q_vld,
  input  wire wwl_pkg::item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output wwl_pkg::result_t    out_res
);
  import wwl_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((LW > 6) ? LW : 6) + 2;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  localparam logic [2:0] ST_HEAD = 3'd0;
  localparam logic [2:0] ST_SPACE = 3'd1;
  localparam logic [2:0] ST_WORD = 3'd2;
  localparam logic [2:0] ST_ACT = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] col_r, col_nxt;
  logic [5:0] row_r, row_nxt;
  logic pend_r, pend_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  item_t item_r, item_nxt;
  logic forced_r, forced_nxt;
  logic ret_fin_r, ret_fin_nxt;
  logic wipe_r, wipe_nxt;
  result_t hold_r, hold_nxt;
  logic hold_vld_r, hold_vld_nxt;
  result_t out_r, out_nxt;
  logic out_vld_r, out_vld_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0] ram_wdata;
  logic ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0] ram_rdata;

  logic [5:0] cpl_e;
  logic [6:0] lpp_e;
  logic [6:0] row_inc;
  logic nl_wrap;
  logic [5:0] nl_row;
  logic col_full;
  logic [5:0] pg_col;
  logic [5:0] pg_row;
  logic pg_wipe;
  logic too_long;
  logic len_full;
  logic [LW-1:0] idx_inc;
  logic out_free;
  logic can_go;
  logic place;
  logic nl_do;
  logic [7:0] pg_chr;
  logic emit_en;
  logic flush_en;
  result_t emit_res;

  wwl_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cpl_e = (cfg.cpl == 6'd0) ? 6'd1 : cfg.cpl;
    if (cfg.lpp == 7'd0) begin
      lpp_e = 7'd1;
    end else if (cfg.lpp > 7'd64) begin
      lpp_e = 7'd64;
    end else begin
      lpp_e = cfg.lpp;
    end
  end

  assign row_inc = {1'b0, row_r} + 7'd1;
  assign nl_wrap = (row_inc >= lpp_e);
  assign nl_row = nl_wrap ? 6'd0 : row_inc[5:0];
  assign col_full = (col_r >= cpl_e);
  assign pg_col = col_full ? 6'd0 : col_r;
  assign pg_row = col_full ? nl_row : row_r;
  assign pg_wipe = wipe_r | (col_full & nl_wrap);
  assign too_long = (SW'(col_r) + SW'(1) + SW'(len_r)) > SW'(cpl_e);
  assign len_full = (len_r == DEPTH_L);
  assign idx_inc = idx_r + LW'(1);
  assign out_free = ~out_vld_r | ~out_stall;
  assign can_go = ~hold_vld_r | out_free;

  always_comb begin
    state_nxt = state_r;
    col_nxt = col_r;
    row_nxt = row_r;
    pend_nxt = pend_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    item_nxt = item_r;
    forced_nxt = forced_r;
    ret_fin_nxt = ret_fin_r;
    wipe_nxt = wipe_r;
    q_pop = 1'b0;
    ram_we = 1'b0;
    ram_waddr = len_r[AW-1:0];
    ram_wdata = item_r.chr;
    ram_re = 1'b0;
    ram_raddr = '0;
    place = 1'b0;
    nl_do = 1'b0;
    pg_chr = item_r.chr;
    emit_en = 1'b0;
    emit_res = '0;
    flush_en = 1'b0;

    case (state_r)
      ST_HEAD: begin
        if (q_vld) begin
          q_pop = 1'b1;
          item_nxt = q_item;
          wipe_nxt = 1'b0;
          if (q_item.cls == CLS_OTHER && pend_r && !len_full) begin
            if (!q_item.eot) begin
              ram_we = 1'b1;
              ram_wdata = q_item.chr;
              len_nxt = len_r + LW'(1);
            end else begin
              state_nxt = ST_ACT;
            end
          end else if (pend_r) begin
            forced_nxt = (q_item.cls == CLS_OTHER);
            ret_fin_nxt = 1'b0;
            state_nxt = ST_SPACE;
          end else begin
            state_nxt = ST_ACT;
          end
        end
      end
      ST_SPACE: begin
        if (can_go) begin
          ram_re = 1'b1;
          ram_raddr = '0;
          idx_nxt = '0;
          if (forced_r || too_long) begin
            nl_do = 1'b1;
          end else begin
            place = 1'b1;
            pg_chr = CH_SPACE;
          end
          if (len_r == '0) begin
            pend_nxt = 1'b0;
            state_nxt = ret_fin_r ? ST_FIN : ST_ACT;
          end else begin
            state_nxt = ST_WORD;
          end
        end
      end
      ST_WORD: begin
        if (can_go) begin
          place = 1'b1;
          pg_chr = ram_rdata;
          idx_nxt = idx_inc;
          ram_raddr = idx_inc[AW-1:0];
          ram_re = (idx_inc != len_r);
          if (idx_inc == len_r) begin
            pend_nxt = 1'b0;
            len_nxt = '0;
            state_nxt = ret_fin_r ? ST_FIN : ST_ACT;
          end
        end
      end
      ST_ACT: begin
        if (can_go) begin
          case (item_r.cls)
            CLS_NL: nl_do = 1'b1;
            CLS_SP: begin
              pend_nxt = 1'b1;
              len_nxt = '0;
            end
            CLS_ZERO: place = 1'b1;
            default: begin
              if (pend_r && !len_full) begin
                ram_we = 1'b1;
                len_nxt = len_r + LW'(1);
              end else begin
                place = 1'b1;
              end
            end
          endcase
          if (item_r.eot && (item_r.cls == CLS_SP || (item_r.cls == CLS_OTHER && pend_r))) begin
            forced_nxt = 1'b0;
            ret_fin_nxt = 1'b1;
            state_nxt = ST_SPACE;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (can_go) begin
          if (wipe_r || item_r.eot) begin
            emit_en = 1'b1;
            emit_res.wipe_before = 1'b1;
            wipe_nxt = 1'b0;
            if (item_r.eot) begin
              col_nxt = 6'd0;
              row_nxt = 6'd0;
            end
            state_nxt = ST_FLUSH;
          end else begin
            flush_en = hold_vld_r;
            state_nxt = ST_HEAD;
          end
        end
      end
      ST_FLUSH: begin
        if (can_go) begin
          flush_en = 1'b1;
          state_nxt = ST_HEAD;
        end
      end
      default: state_nxt = ST_HEAD;
    endcase

    if (nl_do) begin
      col_nxt = 6'd0;
      row_nxt = nl_row;
      wipe_nxt = wipe_r | nl_wrap;
    end
    if (place) begin
      emit_en = 1'b1;
      emit_res.draw = 1'b1;
      emit_res.wipe_before = pg_wipe;
      emit_res.glyph = pg_chr;
      emit_res.column = pg_col;
      emit_res.row = pg_row;
      col_nxt = pg_col + 6'd1;
      row_nxt = pg_row;
      wipe_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r & out_stall;
    out_nxt = out_r;
    hold_nxt = hold_r;
    hold_vld_nxt = hold_vld_r;
    if (emit_en) begin
      if (hold_vld_r) begin
        out_nxt = hold_r;
        out_nxt.last = 1'b0;
        out_vld_nxt = 1'b1;
      end
      hold_nxt = emit_res;
      hold_vld_nxt = 1'b1;
    end else if (flush_en) begin
      out_nxt = hold_r;
      out_nxt.last = 1'b1;
      out_vld_nxt = 1'b1;
      hold_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEAD;
      col_r <= 6'd0;
      row_r <= 6'd0;
      pend_r <= 1'b0;
      len_r <= '0;
      wipe_r <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      pend_r <= pend_nxt;
      len_r <= len_nxt;
      wipe_r <= wipe_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    item_r <= item_nxt;
    forced_r <= forced_nxt;
    ret_fin_r <= ret_fin_nxt;
    hold_r <= hold_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res = out_r;

endmodule
`default_nettype wire

>>> rtl/wwl_checker.sv
// Port-level checks on the result channel of the layout unit, bound to the top level.
`default_nettype none
module wwl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_draw,
  input wire logic       out_wipe_before,
  input wire logic [7:0] out_glyph,
  input wire logic [5:0] out_column,
  input wire logic [5:0] out_row,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_draw) && $stable(out_glyph)
      && $stable(out_column) && $stable(out_row) && $stable(out_last)
      && $stable(out_wipe_before))
    else $error("stalled result beat changed");

  a_wipe_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_draw |-> out_wipe_before)
    else $error("wipe-only beat without its wipe flag");

  a_wipe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_draw |-> out_last)
    else $error("wipe-only beat is not the final beat of its byte");

  a_wipe_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_draw |-> out_glyph == 8'd0 && out_column == 6'd0 && out_row == 6'd0)
    else $error("wipe-only beat carries a position or glyph");

endmodule

bind word_wrap_text_layout_unit wwl_checker u_wwl_checker (.*);
`default_nettype wire
